FILE: hw/rtl/mmf_pkg.sv
package mmf_pkg;

  localparam int DATA_W     = 32;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int FILL_W     = 5;
  localparam int RADIX_BITS = 4;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_COUNT    = 2'd1;

  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = 5'd16;
  localparam logic [CFG_W-1:0] MEAN_COUNT_RESET    = 5'd2;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic  remove;
    logic  insert;
    data_t key;
  } cell_op_t;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_REMOVE = 8'b0000_0010,
    ST_INSERT = 8'b0000_0100,
    ST_MASK   = 8'b0000_1000,
    ST_TREE   = 8'b0001_0000,
    ST_DIVGO  = 8'b0010_0000,
    ST_DIV    = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

endpackage

FILE: hw/rtl/moving_median_filter_core.sv
// Each input transfer runs REMOVE (only when the window is full), INSERT, MASK, TREE,
// DIVGO, DIV and DONE before out_valid; LEVELS = clog2(WINDOW), STEPS = ceil((32 + LEVELS) / 4).
// in_stall is high outside IDLE, so a new sample is not taken until the last one is done.
// The pairwise adder tree folds one level a cycle, and the divider makes 4 bits a cycle in STEPS steps.
// Reset (rst_n low, synchronous) empties the window and restores both registers; cell and
// ring contents stay undefined and need no clearing pass.
module moving_median_filter_core #(
  parameter int WINDOW = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  mmf_pkg::data_t                   in_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output mmf_pkg::data_t                   out_median,
  output mmf_pkg::data_t                   out_central_mean,
  output logic [mmf_pkg::FILL_W-1:0]       out_fill_count,
  input  logic                             cfg_we,
  input  logic [mmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mmf_pkg::CFG_W-1:0]        cfg_wdata
);
  import mmf_pkg::*;

  localparam int LW     = $clog2(WINDOW + 1);
  localparam int PW     = $clog2(WINDOW);
  localparam int LEVELS = $clog2(WINDOW);
  localparam int NP     = 1 << LEVELS;
  localparam int SW     = DATA_W + LEVELS;
  localparam int TW     = $clog2(LEVELS + 1);

  state_t            state_r, state_nxt;
  logic [LW-1:0]     fill_r, fill_nxt;
  logic [PW-1:0]     wp_r, wp_nxt;
  logic [CFG_W-1:0]  wl_r;
  logic [CFG_W-1:0]  mc_r;
  logic [TW-1:0]     lvl_r;
  logic              out_valid_r;
  logic              load_out;
  logic              in_accept;

  logic [LW-1:0]     len_w;
  logic [LW-1:0]     m_w;
  logic [LW-1:0]     start_w;
  logic [LW-1:0]     end_w;
  logic [LW-1:0]     mid_w;

  data_t             ring_mem [WINDOW];
  data_t             ring_rd_r;
  data_t             sample_r;

  cell_op_t          op;
  data_t             cell_val [WINDOW];
  logic              cell_ge  [WINDOW];
  logic              mean_hit [WINDOW];
  logic              med_hit  [WINDOW];

  logic signed [SW-1:0] leaf  [NP];
  logic signed [SW-1:0] acc_r [NP];

  data_t             med_w;
  data_t             median_r;
  data_t             mean_r;
  data_t             out_median_r;
  data_t             out_mean_r;
  logic [FILL_W-1:0] out_fill_r;

  logic              div_start;
  logic              div_done;
  data_t             div_quo;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (wl_r == '0) begin
      len_w = LW'(1);
    end else if (32'(wl_r) > WINDOW) begin
      len_w = LW'(WINDOW);
    end else begin
      len_w = LW'(wl_r);
    end
  end

  always_comb begin
    if (mc_r == '0) begin
      m_w = LW'(1);
    end else if (32'(mc_r) > 32'(fill_r)) begin
      m_w = fill_r;
    end else begin
      m_w = LW'(mc_r);
    end
  end

  assign start_w = (fill_r - m_w) >> 1;
  assign end_w   = start_w + m_w;
  assign mid_w   = (fill_r - 1'b1) >> 1;

  // arrival ring: read the oldest slot and overwrite it in the same transfer
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ring_mem[wp_r] <= in_sample;
      ring_rd_r      <= ring_mem[wp_r];
      sample_r       <= in_sample;
    end
  end

  assign op.remove = (state_r == ST_REMOVE);
  assign op.insert = (state_r == ST_INSERT);
  assign op.key    = (state_r == ST_REMOVE) ? ring_rd_r : sample_r;

  for (genvar j = 0; j < WINDOW; j++) begin : g_cell
    logic  occ;
    logic  tail;
    logic  lge;
    data_t lval;
    data_t rval;

    assign occ = (LW'(j) < fill_r);
    assign tail = (LW'(j) == fill_r);

    if (j == 0) begin : g_first
      assign lval = '0;
      assign lge  = 1'b0;
    end else begin : g_link
      assign lval = cell_val[j-1];
      assign lge  = cell_ge[j-1];
    end

    if (j == WINDOW - 1) begin : g_last
      assign rval = cell_val[j];
    end else begin : g_next
      assign rval = cell_val[j+1];
    end

    mmf_cell u_cell (
      .clk       (clk),
      .op        (op),
      .occ       (occ),
      .tail      (tail),
      .left_val  (lval),
      .left_ge   (lge),
      .right_val (rval),
      .val       (cell_val[j]),
      .ge        (cell_ge[j])
    );

    assign mean_hit[j] = (LW'(j) >= start_w) && (LW'(j) < end_w);
    assign med_hit[j]  = (LW'(j) == mid_w);
  end

  for (genvar j = 0; j < NP; j++) begin : g_leaf
    if (j < WINDOW) begin : g_used
      assign leaf[j] = mean_hit[j] ? SW'(cell_val[j]) : '0;
    end else begin : g_pad
      assign leaf[j] = '0;
    end
  end

  always_comb begin
    med_w = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if (med_hit[j]) med_w = med_w | cell_val[j];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MASK) begin
      for (int j = 0; j < NP; j++) acc_r[j] <= leaf[j];
      median_r <= med_w;
    end else if (state_r == ST_TREE) begin
      // fold one tree level per cycle into the low half
      for (int j = 0; j < NP / 2; j++) acc_r[j] <= acc_r[2*j] + acc_r[2*j+1];
    end
    if ((state_r == ST_DIV) && div_done) mean_r <= div_quo;
  end

  assign div_start = (state_r == ST_DIVGO);

  mmf_div #(
    .SUM_W (SW),
    .DIV_W (LW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r[0]),
    .divisor  (m_w),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    wp_nxt    = wp_r;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if ((LW'(wp_r) + LW'(1)) == len_w) begin
            wp_nxt = '0;
          end else begin
            wp_nxt = wp_r + 1'b1;
          end
          state_nxt = (fill_r == len_w) ? ST_REMOVE : ST_INSERT;
        end
      end
      ST_REMOVE: begin
        fill_nxt  = fill_r - 1'b1;
        state_nxt = ST_INSERT;
      end
      ST_INSERT: begin
        fill_nxt  = fill_r + 1'b1;
        state_nxt = ST_MASK;
      end
      ST_MASK: state_nxt = ST_TREE;
      ST_TREE: begin
        if (lvl_r == '0) state_nxt = ST_DIVGO;
      end
      ST_DIVGO: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free or being drained
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // a new window length drops the whole window
    if (cfg_we && (cfg_index == REG_WINDOW_LENGTH)) begin
      fill_nxt = '0;
      wp_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      wp_r        <= '0;
      wl_r        <= WINDOW_LENGTH_RESET;
      mc_r        <= MEAN_COUNT_RESET;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      wp_r    <= wp_nxt;
      if (cfg_we && (cfg_index == REG_WINDOW_LENGTH)) wl_r <= cfg_wdata;
      if (cfg_we && (cfg_index == REG_MEAN_COUNT))    mc_r <= cfg_wdata;
      if (state_r == ST_MASK) begin
        lvl_r <= TW'(LEVELS - 1);
      end else if ((state_r == ST_TREE) && (lvl_r != '0)) begin
        lvl_r <= lvl_r - 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_median_r <= median_r;
      out_mean_r   <= mean_r;
      out_fill_r   <= FILL_W'(fill_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_median       = out_median_r;
  assign out_central_mean = out_mean_r;
  assign out_fill_count   = out_fill_r;

  a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= len_w)
    else $error("fill exceeds effective window length");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  a_full_evicts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (fill_r == len_w)) |=> (state_r == ST_REMOVE))
    else $error("full window transfer did not evict the oldest sample");

  a_insert_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INSERT) |=> (fill_r != '0))
    else $error("window empty after insert");

endmodule

FILE: hw/rtl/mmf_cell.sv
module mmf_cell (
  input  logic             clk,
  input  mmf_pkg::cell_op_t op,
  input  logic             occ,
  input  logic             tail,
  input  mmf_pkg::data_t   left_val,
  input  logic             left_ge,
  input  mmf_pkg::data_t   right_val,
  output mmf_pkg::data_t   val,
  output logic             ge
);
  import mmf_pkg::*;

  data_t val_r;
  data_t val_nxt;

  // the list is ascending, so every occupied cell at or above the key position sees ge
  assign ge  = occ && ($signed(val_r) >= $signed(op.key));
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (op.remove) begin
      // close the gap: cells from the first match upward pull from the right
      if (ge) val_nxt = right_val;
    end else if (op.insert) begin
      if (left_ge) begin
        val_nxt = left_val;
      end else if (ge || tail) begin
        val_nxt = op.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

FILE: hw/rtl/mmf_div.sv
module mmf_div #(
  parameter int SUM_W = 36,
  parameter int DIV_W = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [DIV_W-1:0]        divisor,
  output logic                    done,
  output mmf_pkg::data_t          quotient
);
  import mmf_pkg::*;

  localparam int QW    = ((SUM_W + RADIX_BITS - 1) / RADIX_BITS) * RADIX_BITS;
  localparam int STEPS = QW / RADIX_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic              busy_r;
  logic              done_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [QW-1:0]     sh_r;
  logic [QW-1:0]     sh_nxt;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  rem_nxt;
  logic [DIV_W-1:0]  dvs_r;
  logic [SUM_W-1:0]  mag;
  logic [DATA_W-1:0] qlo;
  logic              last_step;
  data_t             quo_r;

  assign mag       = dividend[SUM_W-1] ? -dividend : dividend;
  assign qlo       = sh_nxt[DATA_W-1:0];
  assign last_step = busy_r && (cnt_r == CNT_W'(STEPS - 1));

  // restoring division, RADIX_BITS quotient bits per cycle
  always_comb begin
    logic [DIV_W:0]   t;
    logic [QW-1:0]    s;
    logic [DIV_W-1:0] r;
    s = sh_r;
    r = rem_r;
    t = '0;
    for (int k = 0; k < RADIX_BITS; k++) begin
      t = {r, s[QW-1]};
      s = {s[QW-2:0], 1'b0};
      if (t >= {1'b0, dvs_r}) begin
        t    = t - {1'b0, dvs_r};
        s[0] = 1'b1;
      end
      r = t[DIV_W-1:0];
    end
    sh_nxt  = s;
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_step) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_W-1];
      sh_r  <= QW'(mag);
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      sh_r  <= sh_nxt;
      rem_r <= rem_nxt;
    end
    // truncate toward zero: divide the magnitude, then restore the sign
    if (last_step) quo_r <= neg_r ? -qlo : qlo;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
